FILE: rtl/core/thermal_grid_stencil_step_macros.svh
// Assertion helpers for the stencil block; clock aclk, reset aresetn.
`ifndef THERMAL_GRID_STENCIL_STEP_MACROS_SVH
`define THERMAL_GRID_STENCIL_STEP_MACROS_SVH

// Same-cycle implication.
`define TGS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stencil check failed");

// Next-cycle implication.
`define TGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stencil check failed");

`endif

FILE: rtl/core/tgs_pkg.sv
package tgs_pkg;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 3;
    localparam int SUM_W        = 48;
    localparam int TERM_W       = 58;

    // 80.0 in Q16.16
    localparam logic [DATA_W-1:0] AMBIENT_Q16 = 32'h0050_0000;

    localparam logic [IDX_W-1:0] REG_GRID_COLS = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRID_ROWS = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_INV_RX    = 3'd3;
    localparam logic [IDX_W-1:0] REG_INV_RY    = 3'd4;
    localparam logic [IDX_W-1:0] REG_INV_RZ    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_JOB,
        ST_CALC,
        ST_EMIT,
        ST_WRITE
    } tgs_state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] t;
        logic signed [DATA_W-1:0] n;
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] e;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] p;
    } tgs_operands_t;

    typedef struct packed {
        logic [DATA_W-1:0] gain;
        logic [DATA_W-1:0] rx;
        logic [DATA_W-1:0] ry;
        logic [DATA_W-1:0] rz;
    } tgs_coef_t;

endpackage

FILE: rtl/core/tgs_cell.sv
// One cell update: four Q8.24 products, each split into two partial products.
module tgs_cell
    import tgs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  tgs_operands_t            ops,
    input  tgs_coef_t                coef,
    output logic                     done,
    output logic signed [DATA_W-1:0] result
);

    localparam int DIFF_W = DATA_W + 3;
    localparam int HALF_W = SUM_W / 2;

    logic                     busy_reg;
    logic                     done_reg;
    logic [1:0]               op_reg;
    logic [1:0]               ph_reg;
    logic signed [DATA_W-1:0] t_reg;
    logic signed [DIFF_W-1:0] dy_reg, dx_reg, dz_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [HALF_W+DATA_W-1:0] lo_reg;
    logic signed [HALF_W+DATA_W:0] hi_reg;
    logic signed [DATA_W-1:0] res_reg;

    logic signed [SUM_W-1:0]  a_sel;
    logic [DATA_W-1:0]        k_sel;
    logic signed [TERM_W-1:0] term;
    logic signed [TERM_W-1:0] upd;
    logic signed [DIFF_W-1:0] t_x, n_x, s_x, e_x, w_x;

    assign t_x = DIFF_W'(ops.t);
    assign n_x = DIFF_W'(ops.n);
    assign s_x = DIFF_W'(ops.s);
    assign e_x = DIFF_W'(ops.e);
    assign w_x = DIFF_W'(ops.w);

    always_comb begin
        case (op_reg)
            2'd0:    begin a_sel = SUM_W'(dy_reg); k_sel = coef.ry; end
            2'd1:    begin a_sel = SUM_W'(dx_reg); k_sel = coef.rx; end
            2'd2:    begin a_sel = SUM_W'(dz_reg); k_sel = coef.rz; end
            default: begin a_sel = sum_reg;        k_sel = coef.gain; end
        endcase
    end

    assign term = TERM_W'(hi_reg) + TERM_W'({1'b0, lo_reg[HALF_W+DATA_W-1:HALF_W]});
    assign upd  = TERM_W'(t_reg) + term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= 2'd0;
            ph_reg   <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                op_reg   <= 2'd0;
                ph_reg   <= 2'd0;
            end else if (busy_reg) begin
                case (ph_reg)
                    2'd0:    ph_reg <= 2'd1;
                    2'd1:    ph_reg <= 2'd2;
                    default: begin
                        ph_reg <= 2'd0;
                        if (op_reg == 2'd3) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end else begin
                            op_reg <= op_reg + 2'd1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            t_reg   <= ops.t;
            dy_reg  <= n_x + s_x - (t_x <<< 1);
            dx_reg  <= e_x + w_x - (t_x <<< 1);
            dz_reg  <= DIFF_W'(AMBIENT_Q16) - t_x;
            sum_reg <= SUM_W'(ops.p);
        end else if (busy_reg) begin
            case (ph_reg)
                2'd0: lo_reg <= a_sel[HALF_W-1:0] * k_sel;
                2'd1: hi_reg <= $signed(a_sel[SUM_W-1:HALF_W]) * $signed({1'b0, k_sel});
                default: begin
                    if (op_reg != 2'd3) begin
                        sum_reg <= sum_reg + term[SUM_W-1:0];
                    end else if (!upd[TERM_W-1] && (|upd[TERM_W-2:DATA_W-1])) begin
                        res_reg <= {1'b0, {(DATA_W-1){1'b1}}};
                    end else if (upd[TERM_W-1] && !(&upd[TERM_W-2:DATA_W-1])) begin
                        res_reg <= {1'b1, {(DATA_W-1){1'b0}}};
                    end else begin
                        res_reg <= upd[DATA_W-1:0];
                    end
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: rtl/core/thermal_grid_stencil_step.sv
// Thermal grid stencil: one explicit time step of a 5-point heat update.
// Input channel s_*: one word per grid cell in raster order, carrying the
// cell temperature and power (signed Q16.16). Result channel m_*: new
// temperatures (saturated Q16.16) in raster order, one row and one column
// behind the input; m_frame_end marks the last cell of the grid and
// m_run_end the last word caused by one input word (up to four while the
// last row streams). Configuration: cfg_wr_en/cfg_index/cfg_wdata write the
// grid size and the Q8.24 gain and reciprocal resistances; write only while
// the block is idle.
// Throughput: one input word at a time. An item is accepted, reads the line
// buffer memories, picks the next job for each result slot, runs each result
// through the shared cell update unit (four products, each split into two
// partial products, plus the handoff to the output register) and is then
// written back; a stalled receiver holds it up.
// Reset clears counters, window registers and the output valid flag; line
// buffer contents stay undefined until the first rows are streamed.
// A stalled receiver holds the word in the output register; the block
// then waits before loading the next result, and accepts the next input
// word once the current one is written back.
module thermal_grid_stencil_step
    import tgs_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_temperature,
    input  logic signed [DATA_W-1:0] s_power,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_new_temperature,
    output logic                     m_frame_end,
    output logic                     m_run_end,
    input  logic                     cfg_wr_en,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_wdata
);

    localparam int AW    = $clog2(MAX_COLS);
    localparam int CMP_W = 16;
    localparam int ROW_W = 16;

    // Configuration registers
    logic [10:0]       grid_cols_reg;
    logic [ROW_W-1:0]  grid_rows_reg;
    tgs_coef_t         coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg <= 11'd1024;
            grid_rows_reg <= 16'd1024;
            coef_reg      <= {4{32'h0100_0000}};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GRID_COLS: grid_cols_reg <= cfg_wdata[10:0];
                REG_GRID_ROWS: grid_rows_reg <= cfg_wdata[ROW_W-1:0];
                REG_STEP_GAIN: coef_reg.gain <= cfg_wdata;
                REG_INV_RX:    coef_reg.rx   <= cfg_wdata;
                REG_INV_RY:    coef_reg.ry   <= cfg_wdata;
                REG_INV_RZ:    coef_reg.rz   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective grid bounds
    logic [CMP_W-1:0] cols_eff, cols_m1;
    logic [ROW_W-1:0] rows_m1;
    always_comb begin
        cols_eff = (grid_cols_reg == 11'd0) ? CMP_W'(1) : CMP_W'(grid_cols_reg);
        if (cols_eff > CMP_W'(MAX_COLS)) cols_eff = CMP_W'(MAX_COLS);
        cols_m1 = cols_eff - CMP_W'(1);
        rows_m1 = (grid_rows_reg == 16'd0) ? 16'd0 : grid_rows_reg - 16'd1;
    end

    // Control state
    tgs_state_t        state_reg, state_next;
    logic [AW-1:0]     col_cnt_reg;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic              bank_reg;
    logic [2:0]        step_reg;
    logic [1:0]        job_reg;
    logic [3:0]        mask_reg;
    logic              m_valid_reg;

    // Item registers
    logic [AW-1:0]     c_reg;
    logic [ROW_W-1:0]  r_reg;
    logic              c_ge1_reg, c_ge2_reg, r_ge1_reg, r_ge2_reg;
    logic              last_col_reg, last_row_reg;
    logic signed [DATA_W-1:0] cur_t_reg, cur_p_reg;
    logic signed [DATA_W-1:0] win_ppt_reg, win_pt_reg, win_pp_reg;
    logic signed [DATA_W-1:0] mqm1_reg, mq_reg, mc_reg, uq_reg, uc_reg, mpq_reg, mpc_reg;
    logic signed [DATA_W-1:0] m_temp_reg;
    logic              m_fe_reg, m_re_reg;

    // Position of the incoming cell, clamped to the grid
    logic [AW-1:0]    c_now;
    logic [ROW_W-1:0] r_now;
    always_comb begin
        c_now = (CMP_W'(col_cnt_reg) > cols_m1) ? cols_m1[AW-1:0] : col_cnt_reg;
        r_now = (row_cnt_reg > rows_m1) ? rows_m1 : row_cnt_reg;
    end

    logic [AW-1:0] q_addr, qm1_addr;
    assign q_addr   = c_reg - AW'(1);
    assign qm1_addr = c_reg - AW'(2);

    // Line buffers: two temperature banks swap roles each row (upper/middle)
    logic signed [DATA_W-1:0] tmem [2*(2**AW)];
    logic signed [DATA_W-1:0] pmem [MAX_COLS];
    logic signed [DATA_W-1:0] tmem_q, pmem_q;
    logic                     t_rd_en, t_wr_en, p_rd_en, p_wr_en;
    logic [AW:0]              t_addr;
    logic [AW-1:0]            p_addr;
    logic signed [DATA_W-1:0] t_wdata, p_wdata;

    always_ff @(posedge aclk) begin
        if (t_wr_en) tmem[t_addr] <= t_wdata;
        if (t_rd_en) tmem_q <= tmem[t_addr];
    end

    always_ff @(posedge aclk) begin
        if (p_wr_en) pmem[p_addr] <= p_wdata;
        if (p_rd_en) pmem_q <= pmem[p_addr];
    end

    // Memory address sequencing
    always_comb begin
        t_rd_en = 1'b0;
        t_wr_en = 1'b0;
        p_rd_en = 1'b0;
        p_wr_en = 1'b0;
        t_addr  = {bank_reg, q_addr};
        p_addr  = q_addr;
        t_wdata = win_pt_reg;
        p_wdata = win_pp_reg;
        case (state_reg)
            ST_READ: begin
                t_rd_en = (step_reg < 3'd5);
                p_rd_en = (step_reg < 3'd2);
                case (step_reg)
                    3'd0:    t_addr = {bank_reg, qm1_addr};
                    3'd1:    t_addr = {bank_reg, q_addr};
                    3'd2:    t_addr = {bank_reg, c_reg};
                    3'd3:    t_addr = {~bank_reg, q_addr};
                    default: t_addr = {~bank_reg, c_reg};
                endcase
                p_addr = (step_reg == 3'd0) ? q_addr : c_reg;
            end
            ST_WRITE: begin
                if (step_reg == 3'd0) begin
                    t_wr_en = c_ge1_reg;
                    p_wr_en = c_ge1_reg;
                    t_addr  = {~bank_reg, q_addr};
                end else begin
                    t_wr_en = last_col_reg;
                    p_wr_en = last_col_reg;
                    t_addr  = {~bank_reg, c_reg};
                    p_addr  = c_reg;
                    t_wdata = cur_t_reg;
                    p_wdata = cur_p_reg;
                end
            end
            default: ;
        endcase
    end

    // Operands of the selected result
    tgs_operands_t ops;
    logic signed [DATA_W-1:0] ppt;
    assign ppt = c_ge2_reg ? win_ppt_reg : win_pt_reg;

    always_comb begin
        case (job_reg)
            2'd0: begin // row above, previous column
                ops.t = mq_reg;
                ops.n = r_ge2_reg ? uq_reg : mq_reg;
                ops.s = win_pt_reg;
                ops.e = mc_reg;
                ops.w = c_ge2_reg ? mqm1_reg : mq_reg;
                ops.p = mpq_reg;
            end
            2'd1: begin // last row, previous column
                ops.t = win_pt_reg;
                ops.n = r_ge1_reg ? mq_reg : win_pt_reg;
                ops.s = win_pt_reg;
                ops.e = cur_t_reg;
                ops.w = ppt;
                ops.p = win_pp_reg;
            end
            2'd2: begin // row above, last column
                ops.t = mc_reg;
                ops.n = r_ge2_reg ? uc_reg : mc_reg;
                ops.s = cur_t_reg;
                ops.e = mc_reg;
                ops.w = c_ge1_reg ? mq_reg : mc_reg;
                ops.p = mpc_reg;
            end
            default: begin // last row, last column
                ops.t = cur_t_reg;
                ops.n = r_ge1_reg ? mc_reg : cur_t_reg;
                ops.s = cur_t_reg;
                ops.e = cur_t_reg;
                ops.w = c_ge1_reg ? win_pt_reg : cur_t_reg;
                ops.p = cur_p_reg;
            end
        endcase
    end

    logic later_jobs;
    always_comb begin
        case (job_reg)
            2'd0:    later_jobs = |mask_reg[3:1];
            2'd1:    later_jobs = |mask_reg[3:2];
            2'd2:    later_jobs = mask_reg[3];
            default: later_jobs = 1'b0;
        endcase
    end

    logic                     cell_start, cell_done;
    logic signed [DATA_W-1:0] cell_result;

    tgs_cell u_cell (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cell_start),
        .ops     (ops),
        .coef    (coef_reg),
        .done    (cell_done),
        .result  (cell_result)
    );

    logic s_fire, m_free;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_free  = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        cell_start = 1'b0;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_READ;
            ST_READ:  if (step_reg == 3'd5) state_next = ST_JOB;
            ST_JOB: begin
                if (mask_reg[job_reg]) begin
                    cell_start = 1'b1;
                    state_next = ST_CALC;
                end else if (job_reg == 2'd3) begin
                    state_next = ST_WRITE;
                end
            end
            ST_CALC:  if (cell_done) state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_free) state_next = (job_reg == 2'd3) ? ST_WRITE : ST_JOB;
            end
            ST_WRITE: if (step_reg == 3'd1) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 3'd0;
            job_reg     <= 2'd0;
            mask_reg    <= 4'd0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            bank_reg    <= 1'b0;
            win_ppt_reg <= '0;
            win_pt_reg  <= '0;
            win_pp_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !(state_reg == ST_EMIT && m_free))
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    step_reg <= 3'd0;
                    job_reg  <= 2'd0;
                    if (s_fire) begin
                        mask_reg[0] <= (c_now != '0) && (r_now != '0);
                        mask_reg[1] <= (c_now != '0) && (r_now == rows_m1);
                        mask_reg[2] <= (CMP_W'(c_now) == cols_m1) && (r_now != '0);
                        mask_reg[3] <= (CMP_W'(c_now) == cols_m1) && (r_now == rows_m1);
                    end
                end
                ST_READ: begin
                    step_reg <= (step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1;
                end
                ST_JOB: begin
                    // skip results that this cell does not cause
                    if (!mask_reg[job_reg] && job_reg != 2'd3) job_reg <= job_reg + 2'd1;
                end
                ST_EMIT: begin
                    if (m_free) begin
                        m_valid_reg <= 1'b1;
                        if (job_reg != 2'd3) job_reg <= job_reg + 2'd1;
                    end
                end
                ST_WRITE: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd1) begin
                        if (last_col_reg) begin
                            // advance the row and swap the line buffer roles
                            col_cnt_reg <= '0;
                            row_cnt_reg <= last_row_reg ? '0 : r_reg + 16'd1;
                            bank_reg    <= ~bank_reg;
                        end else begin
                            win_ppt_reg <= win_pt_reg;
                            win_pt_reg  <= cur_t_reg;
                            win_pp_reg  <= cur_p_reg;
                            col_cnt_reg <= c_reg + AW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cur_t_reg    <= s_temperature;
            cur_p_reg    <= s_power;
            c_reg        <= c_now;
            r_reg        <= r_now;
            c_ge1_reg    <= (c_now != '0);
            c_ge2_reg    <= (c_now > AW'(1));
            r_ge1_reg    <= (r_now != '0);
            r_ge2_reg    <= (r_now > 16'd1);
            last_col_reg <= (CMP_W'(c_now) == cols_m1);
            last_row_reg <= (r_now == rows_m1);
        end
        if (state_reg == ST_READ) begin
            case (step_reg)
                3'd1:    begin mqm1_reg <= tmem_q; mpq_reg <= pmem_q; end
                3'd2:    begin mq_reg   <= tmem_q; end
                3'd3:    begin mc_reg   <= tmem_q; mpc_reg <= pmem_q; end
                3'd4:    begin uq_reg   <= tmem_q; end
                3'd5:    begin uc_reg   <= tmem_q; end
                default: ;
            endcase
        end
        if (state_reg == ST_EMIT && m_free) begin
            m_temp_reg <= cell_result;
            m_fe_reg   <= (job_reg == 2'd3);
            m_re_reg   <= !later_jobs;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_new_temperature = m_temp_reg;
    assign m_frame_end       = m_fe_reg;
    assign m_run_end         = m_re_reg;

    `include "thermal_grid_stencil_step_macros.svh"

    `TGS_ASSERT_IMP(a_fe_ends_run, m_valid && m_frame_end, m_run_end)
    `TGS_ASSERT_IMP(a_done_in_calc, cell_done, state_reg == ST_CALC)
    `TGS_ASSERT_NEXT(a_accept_reads, s_valid && s_ready, state_reg == ST_READ)
    `TGS_ASSERT_NEXT(a_bank_swap, state_reg == ST_READ, $stable(bank_reg))

endmodule
